>>> design/kinetic_point_order_compare_assert.svh
// Assertion macros used by the comparator top level.
`ifndef KINETIC_POINT_ORDER_COMPARE_ASSERT_SVH
`define KINETIC_POINT_ORDER_COMPARE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define KPOC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpoc assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define KPOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpoc assertion failed");

`endif

>>> design/kpoc_pkg.sv
// Package with constants, frame codes and saturation helpers for the point comparator.
`timescale 1ns / 1ps

package kpoc_pkg;

    // Fixed-point rotation constants: cos 60 is a shift by 15, sin 60 is Q0.16.
    localparam int unsigned COS60_SHIFT = 15;
    localparam logic [16:0] SIN60_Q16   = 17'd56756;

    // Comparison tolerance after reset.
    localparam logic [15:0] EPS_RESET = 16'd1;

    // Frame direction codes.
    typedef enum logic [1:0] {
        FRAME_HORIZ = 2'd0,
        FRAME_UP    = 2'd1,
        FRAME_DOWN  = 2'd2
    } frame_dir_t;

    // Clamp a 49-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v[48:31] == {18{1'b0}} || v[48:31] == {18{1'b1}})
        begin
            r = v[31:0];
        end
        else if (v[48])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

>>> design/kpoc_rotate.sv
// Two-stage rotation of one vector into the selected frame, rounded and saturated.
`timescale 1ns / 1ps

module kpoc_rotate
(
    input  logic               clk,
    input  logic               en_mul,
    input  logic               en_rot,
    input  logic [1:0]         dir,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] ra,
    output logic signed [31:0] rb
);

    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [49:0] as_reg;
    logic signed [49:0] bs_reg;
    logic [1:0]         dir_reg;
    logic signed [31:0] ra_reg;
    logic signed [31:0] rb_reg;
    logic signed [31:0] ra_next;
    logic signed [31:0] rb_next;

    logic signed [50:0] ac_w;
    logic signed [50:0] bc_w;
    logic signed [50:0] as_w;
    logic signed [50:0] bs_w;
    logic signed [50:0] sum_a;
    logic signed [50:0] sum_b;
    logic signed [50:0] rnd_a;
    logic signed [50:0] rnd_b;

    // First stage: the two products by sin 60.
    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            a_reg   <= a;
            b_reg   <= b;
            dir_reg <= dir;
            as_reg  <= a * $signed({1'b0, kpoc_pkg::SIN60_Q16});
            bs_reg  <= b * $signed({1'b0, kpoc_pkg::SIN60_Q16});
        end
    end

    // Second stage: combine with the cos 60 terms, round half up, saturate.
    always_comb
    begin
        ac_w  = {{4{a_reg[31]}}, a_reg, 15'd0};
        bc_w  = {{4{b_reg[31]}}, b_reg, 15'd0};
        as_w  = {as_reg[49], as_reg};
        bs_w  = {bs_reg[49], bs_reg};
        sum_a = ac_w + bs_w;
        sum_b = bc_w - as_w;
        unique case (kpoc_pkg::frame_dir_t'(dir_reg))
            kpoc_pkg::FRAME_DOWN:
            begin
                sum_a = ac_w - bs_w;
                sum_b = bc_w + as_w;
            end
            default:
            begin
                sum_a = ac_w + bs_w;
                sum_b = bc_w - as_w;
            end
        endcase
        rnd_a = sum_a + 51'sd32768;
        rnd_b = sum_b + 51'sd32768;
        ra_next = kpoc_pkg::sat32({{14{rnd_a[50]}}, rnd_a[50:16]});
        rb_next = kpoc_pkg::sat32({{14{rnd_b[50]}}, rnd_b[50:16]});
        if (kpoc_pkg::frame_dir_t'(dir_reg) == kpoc_pkg::FRAME_HORIZ)
        begin
            ra_next = a_reg;
            rb_next = b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_rot)
        begin
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    assign ra = ra_reg;
    assign rb = rb_reg;

endmodule

>>> design/kinetic_point_order_compare.sv
// Top level of the kinetic point order comparator pipeline.
// The slave stream carries one comparison per transfer: s_tuser holds the order
// action and the frame direction, s_tdata holds the time and both moving points.
// The master stream returns one transfer per comparison with p_is_left in bit 0.
// The user must write the tolerance through cfg_wr_en / cfg_wr_data while the block
// is idle; the block does not enforce this. Reset sets it to one Q16.16 unit.
// The datapath has five register stages: two for the frame rotation (multiply,
// then combine and saturate), two for the projection to the current time (the
// 32 by 32 multiply, then round, add and saturate) and one for the ordering.
// One comparison can be accepted every cycle while the output is not stalled.
// Reset clears all stage valid bits, so nothing is presented until new input.
// When the receiver holds m_tready low, the result stays on m_tdata and the
// stages behind it keep filling until every stage is occupied; only then is
// s_tready pulled low. No transfer is lost or repeated.
`timescale 1ns / 1ps
`include "kinetic_point_order_compare_assert.svh"

module kinetic_point_order_compare
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,  // eps_threshold
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [2:0]   s_tuser,      // action, frame_dir[1:0]
    input  logic [287:0] s_tdata,      // cur_time, p_pos_x, p_pos_y, p_vel_x, p_vel_y,
                                       // q_pos_x, q_pos_y, q_vel_x, q_vel_y
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata       // p_is_left, then seven zero bits
);

    logic [15:0] eps_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic en1, en2, en3, en4, en5;

    logic               act1_reg, act2_reg, act3_reg, act4_reg;
    logic signed [31:0] t1_reg, t2_reg;

    logic signed [31:0] ppx_r, ppy_r, pvx_r, pvy_r;
    logic signed [31:0] qpx_r, qpy_r, qvx_r, qvy_r;

    logic signed [63:0] pmx_reg, pmy_reg, qmx_reg, qmy_reg;
    logic signed [31:0] ppx3_reg, ppy3_reg, qpx3_reg, qpy3_reg;
    logic signed [31:0] pvx3_reg, pvy3_reg, qvx3_reg, qvy3_reg;

    logic signed [31:0] px_reg, py_reg, qx_reg, qy_reg;
    logic signed [31:0] pvx4_reg, pvy4_reg, qvx4_reg, qvy4_reg;
    logic signed [31:0] px_next, py_next, qx_next, qy_next;

    logic res_reg;
    logic res_next;

    logic signed [33:0] ex;
    logic x_lt, x_gt, y_gt, y_lt, vx_lt, vx_gt, vy_lt;

    // Tolerance register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= kpoc_pkg::EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            eps_reg <= cfg_wr_data;
        end
    end

    // Stage handshakes: a stage takes new data when it is empty or drains forward.
    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign en1  = rdy1 && s_tvalid;
    assign en2  = rdy2 && v1_reg;
    assign en3  = rdy3 && v2_reg;
    assign en4  = rdy4 && v3_reg;
    assign en5  = rdy5 && v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Side data through the rotation stages.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            act1_reg <= s_tuser[0];
            t1_reg   <= s_tdata[31:0];
        end
        if (en2)
        begin
            act2_reg <= act1_reg;
            t2_reg   <= t1_reg;
        end
    end

    // Frame rotation of both start positions and both velocities.
    kpoc_rotate u_rot_pp
    (
        .clk    (clk),
        .en_mul (en1),
        .en_rot (en2),
        .dir    (s_tuser[2:1]),
        .a      (s_tdata[63:32]),
        .b      (s_tdata[95:64]),
        .ra     (ppx_r),
        .rb     (ppy_r)
    );

    kpoc_rotate u_rot_pv
    (
        .clk    (clk),
        .en_mul (en1),
        .en_rot (en2),
        .dir    (s_tuser[2:1]),
        .a      (s_tdata[127:96]),
        .b      (s_tdata[159:128]),
        .ra     (pvx_r),
        .rb     (pvy_r)
    );

    kpoc_rotate u_rot_qp
    (
        .clk    (clk),
        .en_mul (en1),
        .en_rot (en2),
        .dir    (s_tuser[2:1]),
        .a      (s_tdata[191:160]),
        .b      (s_tdata[223:192]),
        .ra     (qpx_r),
        .rb     (qpy_r)
    );

    kpoc_rotate u_rot_qv
    (
        .clk    (clk),
        .en_mul (en1),
        .en_rot (en2),
        .dir    (s_tuser[2:1]),
        .a      (s_tdata[255:224]),
        .b      (s_tdata[287:256]),
        .ra     (qvx_r),
        .rb     (qvy_r)
    );

    // Third stage: time times rotated velocity, exact in Q32.32.
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            act3_reg <= act2_reg;
            pmx_reg  <= t2_reg * pvx_r;
            pmy_reg  <= t2_reg * pvy_r;
            qmx_reg  <= t2_reg * qvx_r;
            qmy_reg  <= t2_reg * qvy_r;
            ppx3_reg <= ppx_r;
            ppy3_reg <= ppy_r;
            qpx3_reg <= qpx_r;
            qpy3_reg <= qpy_r;
            pvx3_reg <= pvx_r;
            pvy3_reg <= pvy_r;
            qvx3_reg <= qvx_r;
            qvy3_reg <= qvy_r;
        end
    end

    // Fourth stage: round the product half up to Q16.16, add the position, saturate.
    function automatic logic signed [31:0] project(input logic signed [31:0] pos,
                                                   input logic signed [63:0] prod);
        logic signed [63:0] rnd;
        logic signed [48:0] sum;
        rnd = prod + 64'sd32768;
        sum = {rnd[63], rnd[63:16]} + {{17{pos[31]}}, pos};
        return kpoc_pkg::sat32(sum);
    endfunction

    assign px_next = project(ppx3_reg, pmx_reg);
    assign py_next = project(ppy3_reg, pmy_reg);
    assign qx_next = project(qpx3_reg, qmx_reg);
    assign qy_next = project(qpy3_reg, qmy_reg);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            act4_reg <= act3_reg;
            px_reg   <= px_next;
            py_reg   <= py_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            pvx4_reg <= pvx3_reg;
            pvy4_reg <= pvy3_reg;
            qvx4_reg <= qvx3_reg;
            qvy4_reg <= qvy3_reg;
        end
    end

    // Fifth stage: ordering with the tolerance, then the velocity tie-breaks.
    always_comb
    begin
        ex    = $signed({18'd0, eps_reg});
        x_lt  = 34'(px_reg)   < 34'(qx_reg) - ex;
        x_gt  = 34'(qx_reg)   < 34'(px_reg) - ex;
        y_gt  = 34'(py_reg)   > 34'(qy_reg) + ex;
        y_lt  = 34'(py_reg)   < 34'(qy_reg) - ex;
        vx_lt = 34'(pvx4_reg) < 34'(qvx4_reg) - ex;
        vx_gt = 34'(qvx4_reg) < 34'(pvx4_reg) - ex;
        vy_lt = 34'(pvy4_reg) < 34'(qvy4_reg) - ex;
        priority if (x_lt)
        begin
            res_next = 1'b1;
        end
        else if (x_gt)
        begin
            res_next = 1'b0;
        end
        else if (y_gt)
        begin
            res_next = 1'b1;
        end
        else if (y_lt)
        begin
            res_next = 1'b0;
        end
        else if (vx_lt)
        begin
            res_next = !act4_reg;
        end
        else if (vx_gt)
        begin
            res_next = act4_reg;
        end
        else if (vy_lt)
        begin
            res_next = act4_reg;
        end
        else
        begin
            res_next = !act4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            res_reg <= res_next;
        end
    end

    assign s_tready = rdy1;
    assign m_tvalid = v5_reg;
    assign m_tdata  = {7'd0, res_reg};

    // An accepted transfer always occupies the first stage next cycle.
    `KPOC_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v1_reg)
    // Input is refused only when every stage holds an item.
    `KPOC_ASSERT_SAME(a_full_when_busy, !s_tready,
        v1_reg && v2_reg && v3_reg && v4_reg && v5_reg)
    // An item leaving the fourth stage reaches the output register.
    `KPOC_ASSERT_NEXT(a_last_stage_moves, v4_reg && rdy5, m_tvalid)

endmodule
